// ===== hw/rtl/imad_pkg.sv =====
// Package for the IMA ADPCM nibble decoder: item types, opcodes and the step/index tables.
package imad_pkg;

    localparam int SampleW = 16;
    localparam int IndexW  = 7;
    localparam logic [IndexW-1:0] IdxMax = 7'd88;

    typedef enum logic {
        OP_HEADER = 1'b0,
        OP_DATA   = 1'b1
    } imad_op_t;

    // Input item, first member is the MSB
    typedef struct packed {
        logic                      opcode;
        logic signed [SampleW-1:0] header_sample;
        logic [IndexW-1:0]         header_index;
        logic [7:0]                data_byte;
        logic                      end_of_sample;
    } imad_in_t;

    // Result item
    typedef struct packed {
        logic signed [SampleW-1:0] pcm_sample;
        logic                      last_of_item;
        logic                      sample_end;
    } imad_out_t;

    // Decoder state carried from one nibble to the next
    typedef struct packed {
        logic signed [SampleW-1:0] predictor;
        logic [IndexW-1:0]         step_index;
    } imad_state_t;

    // Step size table, 89 entries; indexes past the end read the last entry
    function automatic logic [15:0] imad_step_rom(input logic [IndexW-1:0] idx);
        logic [15:0] v;
        unique case (idx)
            7'd0:  v = 16'd7;     7'd1:  v = 16'd8;     7'd2:  v = 16'd9;
            7'd3:  v = 16'd10;    7'd4:  v = 16'd11;    7'd5:  v = 16'd12;
            7'd6:  v = 16'd13;    7'd7:  v = 16'd14;    7'd8:  v = 16'd16;
            7'd9:  v = 16'd17;    7'd10: v = 16'd19;    7'd11: v = 16'd21;
            7'd12: v = 16'd23;    7'd13: v = 16'd25;    7'd14: v = 16'd28;
            7'd15: v = 16'd31;    7'd16: v = 16'd34;    7'd17: v = 16'd37;
            7'd18: v = 16'd41;    7'd19: v = 16'd45;    7'd20: v = 16'd50;
            7'd21: v = 16'd55;    7'd22: v = 16'd60;    7'd23: v = 16'd66;
            7'd24: v = 16'd73;    7'd25: v = 16'd80;    7'd26: v = 16'd88;
            7'd27: v = 16'd97;    7'd28: v = 16'd107;   7'd29: v = 16'd118;
            7'd30: v = 16'd130;   7'd31: v = 16'd143;   7'd32: v = 16'd157;
            7'd33: v = 16'd173;   7'd34: v = 16'd190;   7'd35: v = 16'd209;
            7'd36: v = 16'd230;   7'd37: v = 16'd253;   7'd38: v = 16'd279;
            7'd39: v = 16'd307;   7'd40: v = 16'd337;   7'd41: v = 16'd371;
            7'd42: v = 16'd408;   7'd43: v = 16'd449;   7'd44: v = 16'd494;
            7'd45: v = 16'd544;   7'd46: v = 16'd598;   7'd47: v = 16'd658;
            7'd48: v = 16'd724;   7'd49: v = 16'd796;   7'd50: v = 16'd876;
            7'd51: v = 16'd963;   7'd52: v = 16'd1060;  7'd53: v = 16'd1166;
            7'd54: v = 16'd1282;  7'd55: v = 16'd1411;  7'd56: v = 16'd1552;
            7'd57: v = 16'd1707;  7'd58: v = 16'd1878;  7'd59: v = 16'd2066;
            7'd60: v = 16'd2272;  7'd61: v = 16'd2499;  7'd62: v = 16'd2749;
            7'd63: v = 16'd3024;  7'd64: v = 16'd3327;  7'd65: v = 16'd3660;
            7'd66: v = 16'd4026;  7'd67: v = 16'd4428;  7'd68: v = 16'd4871;
            7'd69: v = 16'd5358;  7'd70: v = 16'd5894;  7'd71: v = 16'd6484;
            7'd72: v = 16'd7132;  7'd73: v = 16'd7845;  7'd74: v = 16'd8630;
            7'd75: v = 16'd9493;  7'd76: v = 16'd10442; 7'd77: v = 16'd11487;
            7'd78: v = 16'd12635; 7'd79: v = 16'd13899; 7'd80: v = 16'd15289;
            7'd81: v = 16'd16818; 7'd82: v = 16'd18500; 7'd83: v = 16'd20350;
            7'd84: v = 16'd22385; 7'd85: v = 16'd24623; 7'd86: v = 16'd27086;
            7'd87: v = 16'd29794; 7'd88: v = 16'd32767;
            default: v = 16'd32767;
        endcase
        return v;
    endfunction

    // Index adjustment selected by the three magnitude bits
    function automatic logic signed [4:0] imad_index_adj(input logic [2:0] mag);
        logic signed [4:0] a;
        unique case (mag)
            3'd4:    a = 5'sd2;
            3'd5:    a = 5'sd4;
            3'd6:    a = 5'sd6;
            3'd7:    a = 5'sd8;
            default: a = -5'sd1;
        endcase
        return a;
    endfunction

endpackage

// ===== hw/rtl/imad_nibble_step.sv =====
// One nibble decode step: step lookup, difference sum, predictor and index update.
module imad_nibble_step
    import imad_pkg::*;
(
    input  imad_state_t cur,
    input  logic [3:0]  nibble,
    output imad_state_t nxt
);

    logic [IndexW-1:0] idx;
    logic [15:0]       step;
    logic [16:0]       diff;
    logic signed [17:0] pred_ext;
    logic signed [17:0] diff_ext;
    logic signed [17:0] sum;
    logic signed [7:0]  ni;
    logic signed [4:0]  adj;
    logic signed [SampleW-1:0] pred_new;
    logic [IndexW-1:0]         idx_new;

    // Difference: truncated step fractions picked by the magnitude bits
    always_comb begin
        idx  = (cur.step_index > IdxMax) ? IdxMax : cur.step_index;
        step = imad_step_rom(idx);
        diff = 17'(step >> 3);
        if (nibble[0]) diff = diff + 17'(step >> 2);
        if (nibble[1]) diff = diff + 17'(step >> 1);
        if (nibble[2]) diff = diff + 17'(step);
    end

    // Predictor update with saturation
    always_comb begin
        pred_ext = {{2{cur.predictor[15]}}, cur.predictor};
        diff_ext = $signed({1'b0, diff});
        if (nibble[3]) begin
            sum = pred_ext - diff_ext;
        end else begin
            sum = pred_ext + diff_ext;
        end
        if (sum > 18'sd32767) begin
            pred_new = 16'sh7FFF;
        end else if (sum < -18'sd32768) begin
            pred_new = 16'sh8000;
        end else begin
            pred_new = sum[15:0];
        end
    end

    // Step index update, clamped to the table range
    always_comb begin
        adj = imad_index_adj(nibble[2:0]);
        ni  = $signed({1'b0, idx}) + $signed({{3{adj[4]}}, adj});
        if (ni < 8'sd0) begin
            idx_new = '0;
        end else if (ni > $signed({1'b0, IdxMax})) begin
            idx_new = IdxMax;
        end else begin
            idx_new = ni[IndexW-1:0];
        end
    end

    assign nxt = '{predictor: pred_new, step_index: idx_new};

endmodule

// ===== hw/rtl/ima_adpcm_nibble_decoder.sv =====
// Top level: input holding register, nibble step unit and result register.
// An accepted item waits in the holding register; its results are then loaded into the result register.
// A header item gives one result, a data byte two (two dependent nibble steps
// through the single step unit), one result per cycle on m_ while m_ready does not stall it.
// Reset (aresetn low, synchronous): both registers empty, predictor and index zero.
module ima_adpcm_nibble_decoder
    import imad_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  imad_in_t  s_payload,
    output logic      m_valid,
    input  logic      m_ready,
    output imad_out_t m_payload
);

    logic        hold_valid_reg;
    imad_in_t    hold_reg;
    logic        phase_reg;
    imad_state_t state_reg;
    logic        out_valid_reg;
    imad_out_t   out_reg;

    logic        out_load;
    logic        fire;
    logic        is_data;
    logic        done;
    logic [3:0]  nibble;
    imad_state_t step_nxt;
    imad_state_t state_next;
    imad_out_t   out_next;

    // Handshake control
    assign out_load = !out_valid_reg || m_ready;
    assign is_data  = (hold_reg.opcode == OP_DATA);
    assign fire     = hold_valid_reg && out_load;
    assign done     = fire && (!is_data || phase_reg);
    assign s_ready  = !hold_valid_reg || done;
    assign nibble   = phase_reg ? hold_reg.data_byte[7:4] : hold_reg.data_byte[3:0];

    imad_nibble_step u_step (
        .cur    (state_reg),
        .nibble (nibble),
        .nxt    (step_nxt)
    );

    // Next state and result for the item in the holding register
    always_comb begin
        if (is_data) begin
            state_next            = step_nxt;
            out_next.pcm_sample   = step_nxt.predictor;
            out_next.last_of_item = phase_reg;
            out_next.sample_end   = phase_reg && hold_reg.end_of_sample;
        end else begin
            state_next.predictor  = hold_reg.header_sample;
            state_next.step_index = (hold_reg.header_index > IdxMax) ?
                                    IdxMax : hold_reg.header_index;
            out_next.pcm_sample   = hold_reg.header_sample;
            out_next.last_of_item = 1'b1;
            out_next.sample_end   = 1'b0;
        end
    end

    // Input holding register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            hold_valid_reg <= 1'b1;
        end else if (done) begin
            hold_valid_reg <= 1'b0;
        end
        if (s_valid && s_ready) begin
            hold_reg <= s_payload;
        end
    end

    // Nibble phase and decoder state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= 1'b0;
            state_reg <= '0;
        end else if (fire) begin
            phase_reg <= is_data && !phase_reg;
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= fire;
        end
        if (fire) begin
            out_reg <= out_next;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_payload = out_reg;

endmodule

// ===== hw/rtl/imad_checker.sv =====
// Port-level checker for the IMA ADPCM nibble decoder, bound to the top level.
module imad_checker
    import imad_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input imad_in_t  s_payload,
    input logic      m_valid,
    input logic      m_ready,
    input imad_out_t m_payload
);

    // A stalled input item holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_payload))
        else $error("input item changed while stalled");

    // A stalled result item holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("result item changed while stalled");

    // End of sample only on the final result of an item
    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.sample_end |-> m_payload.last_of_item)
        else $error("sample_end without last_of_item");

    // An accepted item is followed by a valid result
    a_result_due: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |-> ##2 m_valid)
        else $error("no result after accepted item");

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind ima_adpcm_nibble_decoder imad_checker u_imad_checker (.*);

// ===== test/tb_ima_adpcm_nibble_decoder.sv =====
// Testbench for the IMA ADPCM nibble decoder: random and directed items checked against a local decoder.
`timescale 1ns / 100ps

module tb_ima_adpcm_nibble_decoder
    import imad_pkg::*;
();

    localparam int RANDOM_ITEMS = 1600;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 10;
    localparam int STALL_AT     = 500;
    localparam int STALL_LEN    = 300;
    localparam int MAX_PRINTS   = 40;
    localparam int INDEX_TOP    = 88;

    // Step sizes indexed by the step index
    localparam int STEP_SIZE [0:88] = '{
        7, 8, 9, 10, 11, 12, 13, 14, 16, 17, 19, 21, 23, 25, 28, 31, 34, 37,
        41, 45, 50, 55, 60, 66, 73, 80, 88, 97, 107, 118, 130, 143, 157, 173,
        190, 209, 230, 253, 279, 307, 337, 371, 408, 449, 494, 544, 598, 658,
        724, 796, 876, 963, 1060, 1166, 1282, 1411, 1552, 1707, 1878, 2066,
        2272, 2499, 2749, 3024, 3327, 3660, 4026, 4428, 4871, 5358, 5894, 6484,
        7132, 7845, 8630, 9493, 10442, 11487, 12635, 13899, 15289, 16818, 18500,
        20350, 22385, 24623, 27086, 29794, 32767
    };

    // Index movement per magnitude code
    localparam int INDEX_MOVE [0:7] = '{-1, -1, -1, -1, 2, 4, 6, 8};

    logic      aclk;
    logic      aresetn   = 1'b0;
    logic      s_valid   = 1'b0;
    logic      s_ready;
    imad_in_t  s_payload = '0;
    logic      m_valid;
    logic      m_ready   = 1'b0;
    imad_out_t m_payload;

    imad_in_t  pending_items[$];
    imad_out_t expected_samples[$];

    int n_total    = 0;
    int n_accepted = 0;
    int n_errors   = 0;
    int stall_left = 0;
    bit stall_done = 1'b0;

    // Local copy of the decoder state
    logic signed [SampleW-1:0] cur_pred  = '0;
    logic [IndexW-1:0]         cur_index = '0;

    ima_adpcm_nibble_decoder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    task automatic report_mismatch(input string msg);
        if (n_errors < MAX_PRINTS) begin
            $display("MISMATCH: %s", msg);
        end
        n_errors++;
    endtask

    // Append to the stimulus queue
    function automatic void add_pending(input imad_in_t it);
        pending_items.insert(pending_items.size(), it);
    endfunction

    // Append to the expected result queue
    function automatic void add_expected(input imad_out_t r);
        expected_samples.insert(expected_samples.size(), r);
    endfunction

    // One nibble step on the local state
    function automatic void decode_nibble(input logic [3:0] nib);
        int step;
        int diff;
        int s;
        int ni;
        step = STEP_SIZE[cur_index];
        diff = step / 8;
        if (nib[0]) diff += step / 4;
        if (nib[1]) diff += step / 2;
        if (nib[2]) diff += step;
        if (nib[3]) begin
            s = int'(cur_pred) - diff;
            if (s < -32768) s = -32768;
        end else begin
            s = int'(cur_pred) + diff;
            if (s > 32767) s = 32767;
        end
        cur_pred = s[SampleW-1:0];
        ni = int'(cur_index) + INDEX_MOVE[nib[2:0]];
        if (ni < 0) ni = 0;
        if (ni > INDEX_TOP) ni = INDEX_TOP;
        cur_index = ni[IndexW-1:0];
    endfunction

    // Queue the samples that one accepted item produces
    function automatic void predict_samples(input imad_in_t it);
        imad_out_t r;
        if (it.opcode == OP_HEADER) begin
            cur_pred  = it.header_sample;
            cur_index = (it.header_index > IdxMax) ? IdxMax : it.header_index;
            r.pcm_sample   = cur_pred;
            r.last_of_item = 1'b1;
            r.sample_end   = 1'b0;
            add_expected(r);
        end else begin
            decode_nibble(it.data_byte[3:0]);
            r.pcm_sample   = cur_pred;
            r.last_of_item = 1'b0;
            r.sample_end   = 1'b0;
            add_expected(r);
            decode_nibble(it.data_byte[7:4]);
            r.pcm_sample   = cur_pred;
            r.last_of_item = 1'b1;
            r.sample_end   = it.end_of_sample;
            add_expected(r);
        end
    endfunction

    // Header item; unused fields carry random junk
    function automatic imad_in_t make_header(input logic [15:0] smp, input logic [6:0] idx);
        imad_in_t it;
        it.opcode        = OP_HEADER;
        it.header_sample = smp;
        it.header_index  = idx;
        it.data_byte     = 8'($urandom);
        it.end_of_sample = 1'($urandom);
        return it;
    endfunction

    // Data item; header fields carry random junk
    function automatic imad_in_t make_data(input logic [7:0] byte_val, input logic eos);
        imad_in_t it;
        it.opcode        = OP_DATA;
        it.header_sample = 16'($urandom);
        it.header_index  = 7'($urandom);
        it.data_byte     = byte_val;
        it.end_of_sample = eos;
        return it;
    endfunction

    // Idle rates by thirds of the run
    function automatic int run_phase();
        return (n_total == 0) ? 2 : (n_accepted * 3) / n_total;
    endfunction

    function automatic int sender_idle_pct();
        case (run_phase())
            0:       return 13;
            1:       return 46;
            default: return 0;
        endcase
    endfunction

    function automatic int recv_idle_pct();
        case (run_phase())
            0:       return 46;
            1:       return 13;
            default: return 0;
        endcase
    endfunction

    // Driver: offers items from the pending queue
    always @(posedge aclk) begin : driver
        logic taken;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            taken = s_valid && s_ready;
            if (taken) n_accepted <= n_accepted + 1;
            if (!s_valid || taken) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct()) begin
                    s_valid   <= 1'b1;
                    s_payload <= pending_items.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // One long receiver hold-off to back up the block
    always @(posedge aclk) begin : stall_count
        if (!aresetn) begin
            stall_left <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else if (!stall_done && n_accepted >= STALL_AT) begin
            stall_done <= 1'b1;
            stall_left <= STALL_LEN;
        end
    end

    // Monitor: predicts on input items, checks result items, drives m_ready
    always @(posedge aclk) begin : monitor
        imad_out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (s_valid && s_ready) predict_samples(s_payload);
            if (m_valid && m_ready) begin
                if (expected_samples.size() == 0) begin
                    report_mismatch($sformatf("unexpected item pcm=%0d last=%0b end=%0b",
                        m_payload.pcm_sample, m_payload.last_of_item, m_payload.sample_end));
                end else begin
                    want = expected_samples.pop_front();
                    if (m_payload.pcm_sample !== want.pcm_sample
                            || m_payload.last_of_item !== want.last_of_item
                            || m_payload.sample_end !== want.sample_end) begin
                        report_mismatch($sformatf(
                            "pcm=%0d last=%0b end=%0b, want pcm=%0d last=%0b end=%0b",
                            m_payload.pcm_sample, m_payload.last_of_item,
                            m_payload.sample_end, want.pcm_sample, want.last_of_item,
                            want.sample_end));
                    end
                end
            end
            // held off during the long stall, random stalls otherwise
            if (stall_left > 0) begin
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct());
            end
        end
    end

    // Timeout
    initial begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // Stimulus and end of run
    initial begin : stimulus
        int n_bytes;
        int sel;
        logic [15:0] smp;

        // data before any header decodes from the reset state
        add_pending(make_data(8'h00, 1'b0));
        add_pending(make_data(8'hFF, 1'b0));
        add_pending(make_data(8'h88, 1'b0));
        add_pending(make_data(8'h77, 1'b1));
        // index floor
        add_pending(make_header(16'h0000, 7'd0));
        add_pending(make_data(8'h33, 1'b0));
        add_pending(make_data(8'h00, 1'b1));
        // header index above the table saturates; positive clamp
        add_pending(make_header(16'h7FFF, 7'd127));
        add_pending(make_data(8'h77, 1'b0));
        add_pending(make_data(8'h07, 1'b1));
        // negative clamp
        add_pending(make_header(16'h8000, 7'd89));
        add_pending(make_data(8'hFF, 1'b0));
        add_pending(make_data(8'h8F, 1'b1));
        // top valid index, mixed signs
        add_pending(make_header(16'h8000, 7'd88));
        add_pending(make_data(8'h70, 1'b0));
        add_pending(make_data(8'h5A, 1'b0));
        add_pending(make_data(8'hA5, 1'b1));
        add_pending(make_header(16'hFFFF, 7'd1));
        add_pending(make_data(8'h12, 1'b0));
        add_pending(make_data(8'hC4, 1'b1));
        add_pending(make_header(16'h0001, 7'd64));
        add_pending(make_data(8'hE9, 1'b1));

        // random: mostly header followed by a block of bytes, some stray items
        while (pending_items.size() < 22 + RANDOM_ITEMS) begin
            if ($urandom_range(9) == 0) begin
                if ($urandom_range(1) == 0) begin
                    add_pending(make_data(8'($urandom), 1'($urandom)));
                end else begin
                    add_pending(make_header(16'($urandom), 7'($urandom)));
                end
            end else begin
                sel = $urandom_range(7);
                smp = (sel == 0) ? 16'h7FFF : (sel == 1) ? 16'h8000 : 16'($urandom);
                add_pending(make_header(smp, 7'($urandom_range(127))));
                n_bytes = $urandom_range(1, 40);
                for (int i = 0; i < n_bytes; i++) begin
                    add_pending(make_data(8'($urandom), i == n_bytes - 1));
                end
            end
        end
        n_total = pending_items.size();

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        @(negedge aclk);
        while (pending_items.size() != 0 || s_valid || expected_samples.size() != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (n_errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/imad_pkg.sv
hw/rtl/imad_nibble_step.sv
hw/rtl/ima_adpcm_nibble_decoder.sv
hw/rtl/imad_checker.sv
test/tb_ima_adpcm_nibble_decoder.sv
